/* hdl/assert_macros.svh */
// Assertion macros for the RTL that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that prop holds at every rising clock edge outside reset.
`define ASSERT_AT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

// Check that cond never holds at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("forbidden condition seen");

`endif

/* hdl/ddap_pkg.sv */
// Constants for the dotted decimal address parser.
package ddap_pkg;

  localparam int unsigned CharW    = 8;
  localparam int unsigned AccW     = 8;
  localparam int unsigned ProdW    = AccW + 4;
  localparam int unsigned ValueW   = 32;
  localparam int unsigned CountW   = 3;
  localparam int unsigned DataOutW = ((ValueW + CountW + 7) / 8) * 8;

  localparam logic [ProdW-1:0]  PartMax  = ProdW'(255);
  localparam logic [CountW-1:0] MaxParts = CountW'(4);

  localparam logic [CharW-1:0] CharZero  = 8'h30;
  localparam logic [CharW-1:0] CharNine  = 8'h39;
  localparam logic [CharW-1:0] CharDot   = 8'h2E;
  localparam logic [CharW-1:0] CharSpace = 8'h20;
  localparam logic [CharW-1:0] CharTab   = 8'h09;

endpackage

/* hdl/dotted_decimal_address_parser_core.sv */
// Dotted decimal address parser: text stream in, one parse result per string.
//
// Usage:
//   The slave stream carries one ASCII byte per request in s_axis_tdata_i;
//   s_axis_tlast_i marks the terminator request, whose byte is ignored.
//   On each terminator the master stream gives one result request:
//   tuser = accepted flag, tdata = packed parts (first part most
//   significant) and the part count. Rejected text gives all zeros.
//   cfg_we_i/cfg_wdata_i write the mode bit: 0 needs exactly four parts,
//   1 accepts one to four. Write it only while no string is in flight.
// Throughput and data path:
//   One byte per cycle sustained while no terminator waits for the result
//   slot. A request passes an input register and the parse logic (decode,
//   multiply by ten, compare against 255) into the result register, which
//   drives m_axis_tvalid_o.
// Reset:
//   Parser state returns to leading whitespace, no result pending, mode 0.
// Stall:
//   While a result waits on m_axis_tready_i, plain bytes keep flowing; only
//   the next terminator holds in the input register until the slot frees.
`include "assert_macros.svh"

module dotted_decimal_address_parser_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic                          cfg_wdata_i,    // accept_mode
  // slave stream
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [ddap_pkg::CharW-1:0]    s_axis_tdata_i, // [7:0] character
  input  logic                          s_axis_tlast_i, // is_end
  // master stream
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [31:0] packed_value, [34:32] part_count, upper bits zero
  output logic [ddap_pkg::DataOutW-1:0] m_axis_tdata_o,
  output logic                          m_axis_tuser_o  // accepted
);

  typedef enum logic [1:0] {
    PhLead,
    PhPart,
    PhTrail
  } phase_e;

  localparam int unsigned AccW   = ddap_pkg::AccW;
  localparam int unsigned ProdW  = ddap_pkg::ProdW;
  localparam int unsigned ValueW = ddap_pkg::ValueW;
  localparam int unsigned CountW = ddap_pkg::CountW;
  localparam int unsigned PadW   = ddap_pkg::DataOutW - ValueW - CountW;

  // mode register
  logic mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  // input register
  logic                       s1_valid_q;
  logic [ddap_pkg::CharW-1:0] s1_char_q;
  logic                       s1_last_q;
  logic                       out_free;
  logic                       consume;

  assign out_free        = !m_axis_tvalid_o || m_axis_tready_i;
  // plain bytes never wait; a terminator waits for the result slot
  assign consume         = s1_valid_q && (!s1_last_q || out_free);
  assign s_axis_tready_o = !s1_valid_q || consume;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      s1_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      s1_char_q <= s_axis_tdata_i;
      s1_last_q <= s_axis_tlast_i;
    end
  end

  // parse state
  phase_e            phase_q, phase_d;
  logic [AccW-1:0]   acc_q, acc_d;
  logic              has_digit_q, has_digit_d;
  logic [CountW-1:0] parts_q, parts_d;
  logic [ValueW-1:0] packed_q, packed_d;
  logic              rej_q, rej_d;

  // result register
  logic              out_valid_q, out_valid_d;
  logic              out_ok_q, out_ok_d;
  logic [ValueW-1:0] out_value_q, out_value_d;
  logic [CountW-1:0] out_count_q, out_count_d;

  logic              is_digit;
  logic              is_blank;
  logic              is_dot;
  logic [ProdW-1:0]  prod;
  logic              can_close;
  logic [ValueW-1:0] packed_closed;
  logic [CountW-1:0] parts_closed;
  logic [ValueW-1:0] fin_value;
  logic [CountW-1:0] fin_count;
  logic              fin_shape_ok;
  logic              fin_count_ok;
  logic              fin_ok;

  always_comb begin
    is_digit = s1_char_q inside {[ddap_pkg::CharZero:ddap_pkg::CharNine]};
    is_blank = s1_char_q inside {ddap_pkg::CharSpace, ddap_pkg::CharTab};
    is_dot   = (s1_char_q == ddap_pkg::CharDot);
    // acc * 10 + digit as two shifts and adds
    prod = ({{(ProdW-AccW){1'b0}}, acc_q} << 3)
         + ({{(ProdW-AccW){1'b0}}, acc_q} << 1)
         + {{(ProdW-4){1'b0}}, s1_char_q[3:0]};
    can_close     = has_digit_q && (parts_q < ddap_pkg::MaxParts);
    packed_closed = {packed_q[ValueW-AccW-1:0], acc_q};
    parts_closed  = parts_q + CountW'(1);

    // terminator: close an open part, then check the count against the mode
    fin_value    = (phase_q == PhPart) ? packed_closed : packed_q;
    fin_count    = (phase_q == PhPart) ? parts_closed : parts_q;
    fin_shape_ok = ((phase_q == PhPart) && can_close) || (phase_q == PhTrail);
    fin_count_ok = mode_q ? ((fin_count != '0) && (fin_count <= ddap_pkg::MaxParts))
                          : (fin_count == ddap_pkg::MaxParts);
    fin_ok       = !rej_q && fin_shape_ok && fin_count_ok;
  end

  always_comb begin
    phase_d     = phase_q;
    acc_d       = acc_q;
    has_digit_d = has_digit_q;
    parts_d     = parts_q;
    packed_d    = packed_q;
    rej_d       = rej_q;
    out_valid_d = m_axis_tvalid_o && !m_axis_tready_i;
    out_ok_d    = out_ok_q;
    out_value_d = out_value_q;
    out_count_d = out_count_q;

    if (consume && s1_last_q) begin
      out_valid_d = 1'b1;
      out_ok_d    = fin_ok;
      out_value_d = fin_ok ? fin_value : '0;
      out_count_d = fin_ok ? fin_count : '0;
      // start over for the next string
      phase_d     = PhLead;
      acc_d       = '0;
      has_digit_d = 1'b0;
      parts_d     = '0;
      packed_d    = '0;
      rej_d       = 1'b0;
    end else if (consume && !rej_q) begin
      case (phase_q)
        PhLead: begin
          if (is_digit) begin
            phase_d     = PhPart;
            acc_d       = {{(AccW-4){1'b0}}, s1_char_q[3:0]};
            has_digit_d = 1'b1;
          end else if (!is_blank) begin
            rej_d = 1'b1;
          end
        end
        PhPart: begin
          if (is_digit) begin
            if (prod > ddap_pkg::PartMax) begin
              rej_d = 1'b1;
            end else begin
              acc_d       = prod[AccW-1:0];
              has_digit_d = 1'b1;
            end
          end else if (!can_close) begin
            rej_d = 1'b1;
          end else begin
            packed_d    = packed_closed;
            parts_d     = parts_closed;
            acc_d       = '0;
            has_digit_d = 1'b0;
            if (is_blank) begin
              phase_d = PhTrail;
            end else if (!is_dot) begin
              rej_d = 1'b1;
            end
          end
        end
        PhTrail: begin
          if (!is_blank) begin
            rej_d = 1'b1;
          end
        end
        default: begin
          rej_d = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhLead;
      acc_q       <= '0;
      has_digit_q <= 1'b0;
      parts_q     <= '0;
      packed_q    <= '0;
      rej_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      acc_q       <= acc_d;
      has_digit_q <= has_digit_d;
      parts_q     <= parts_d;
      packed_q    <= packed_d;
      rej_q       <= rej_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_ok_q    <= out_ok_d;
    out_value_q <= out_value_d;
    out_count_q <= out_count_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_ok_q;
  assign m_axis_tdata_o  = {{PadW{1'b0}}, out_count_q, out_value_q};

  // checks
  `ASSERT_AT(a_reject_zero, clk_i, rst_ni,
    (out_valid_q && !out_ok_q) |-> (out_value_q == '0 && out_count_q == '0))
  `ASSERT_AT(a_ok_count, clk_i, rst_ni,
    (out_valid_q && out_ok_q) |-> (out_count_q != '0 && out_count_q <= ddap_pkg::MaxParts))
  `ASSERT_AT(a_clear_after_end, clk_i, rst_ni,
    (consume && s1_last_q) |=> (phase_q == PhLead && parts_q == '0 && !rej_q))
  `ASSERT_NEVER(a_parts_range, clk_i, rst_ni, parts_q > ddap_pkg::MaxParts)

endmodule

/* tb/dotted_decimal_address_parser_core_tb.sv */
// Testbench for the dotted decimal address parser core: random text streams against a predictor.
`timescale 1ns / 100ps

module dotted_decimal_address_parser_core_tb;

  // Cycles with no request moving on either side before the run is called hung.
  localparam int unsigned IdleLimit     = 2000;
  // Extra cycles after the last result, so a stray byte can leave the pipeline.
  localparam int unsigned DrainCycles   = 4;
  localparam int unsigned ItemsPerPhase = 200;
  localparam int unsigned NumPhases     = 8;

  typedef enum logic [2:0] {
    PhaseLead  = 3'd0,
    PhasePart  = 3'd1,
    PhaseTrail = 3'd2
  } parse_phase_e;

  typedef struct packed {
    logic                        accepted;
    logic [ddap_pkg::ValueW-1:0] packed_value;
    logic [ddap_pkg::CountW-1:0] part_count;
  } parse_result_t;

  // Tracks the parse of the text in flight and holds the results still owed.
  class addr_parse_scoreboard;
    parse_phase_e                cur_phase;
    int unsigned                 part_value;
    bit                          part_has_num;
    int unsigned                 part_total;
    logic [ddap_pkg::ValueW-1:0] value_shift;
    bit                          text_rejected;
    bit                          net_mode;
    parse_result_t               owed_q[$];
    int unsigned                 error_count;

    function new();
      net_mode    = 1'b0;
      error_count = 0;
      restart();
    endfunction

    function void restart();
      cur_phase     = PhaseLead;
      part_value    = 0;
      part_has_num  = 1'b0;
      part_total    = 0;
      value_shift   = '0;
      text_rejected = 1'b0;
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction

    // Shift the current part in; refuse when it is empty or a fifth one.
    function bit close_part();
      if (!part_has_num || part_total >= ddap_pkg::MaxParts) return 1'b0;
      value_shift  = {value_shift[ddap_pkg::ValueW-9:0], part_value[7:0]};
      part_total++;
      part_value   = 0;
      part_has_num = 1'b0;
      return 1'b1;
    endfunction

    function void take_char(logic [ddap_pkg::CharW-1:0] c);
      bit          is_digit = (c >= ddap_pkg::CharZero && c <= ddap_pkg::CharNine);
      bit          is_blank = (c == ddap_pkg::CharSpace || c == ddap_pkg::CharTab);
      int unsigned next_value;
      case (cur_phase)
        PhaseLead: begin
          if (is_digit) begin
            cur_phase    = PhasePart;
            part_value   = 32'(c - ddap_pkg::CharZero);
            part_has_num = 1'b1;
          end else if (!is_blank) begin
            text_rejected = 1'b1;
          end
        end
        PhasePart: begin
          if (is_digit) begin
            next_value = part_value * 10 + 32'(c - ddap_pkg::CharZero);
            if (next_value > ddap_pkg::PartMax) begin
              text_rejected = 1'b1;
            end else begin
              part_value   = next_value;
              part_has_num = 1'b1;
            end
          end else if (!close_part()) begin
            text_rejected = 1'b1;
          end else if (is_blank) begin
            cur_phase = PhaseTrail;
          end else if (c != ddap_pkg::CharDot) begin
            text_rejected = 1'b1;
          end
        end
        PhaseTrail: begin
          if (!is_blank) text_rejected = 1'b1;
        end
        default: begin
          text_rejected = 1'b1;
        end
      endcase
    endfunction

    function void note_request(logic [ddap_pkg::CharW-1:0] c, logic last);
      parse_result_t res;
      bit            ok;
      if (!last) begin
        if (!text_rejected) take_char(c);
        return;
      end
      ok = !text_rejected;
      if (ok) begin
        if (cur_phase == PhasePart) ok = close_part();
        else if (cur_phase != PhaseTrail) ok = 1'b0;
      end
      if (ok) begin
        ok = net_mode ? (part_total >= 1 && part_total <= ddap_pkg::MaxParts)
                      : (part_total == ddap_pkg::MaxParts);
      end
      res.accepted     = ok;
      res.packed_value = ok ? value_shift : '0;
      res.part_count   = ok ? ddap_pkg::CountW'(part_total) : '0;
      owed_q.push_back(res);
      restart();
    endfunction

    function void check_result(logic flag, logic [ddap_pkg::DataOutW-1:0] data);
      parse_result_t want;
      if (owed_q.size() == 0) begin
        $error("result with no terminator pending: tuser=%0b tdata=%h", flag, data);
        error_count++;
        return;
      end
      want = owed_q.pop_front();
      if (flag !== want.accepted) begin
        $error("accepted: expected %0b, got %0b", want.accepted, flag);
        error_count++;
      end
      if (data[ddap_pkg::ValueW-1:0] !== want.packed_value) begin
        $error("packed_value: expected %h, got %h", want.packed_value,
               data[ddap_pkg::ValueW-1:0]);
        error_count++;
      end
      if (data[ddap_pkg::ValueW +: ddap_pkg::CountW] !== want.part_count) begin
        $error("part_count: expected %0d, got %0d", want.part_count,
               data[ddap_pkg::ValueW +: ddap_pkg::CountW]);
        error_count++;
      end
      if (data[ddap_pkg::DataOutW-1:ddap_pkg::ValueW+ddap_pkg::CountW] !== '0) begin
        $error("tdata padding: expected 0, got %h",
               data[ddap_pkg::DataOutW-1:ddap_pkg::ValueW+ddap_pkg::CountW]);
        error_count++;
      end
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni          = 1'b0;
  logic                          cfg_we_i        = 1'b0;
  logic                          cfg_wdata_i     = 1'b0;
  logic                          s_axis_tvalid_i = 1'b0;
  logic                          s_axis_tready_o;
  logic [ddap_pkg::CharW-1:0]    s_axis_tdata_i  = '0;
  logic                          s_axis_tlast_i  = 1'b0;
  logic                          m_axis_tvalid_o;
  logic                          m_axis_tready_i = 1'b0;
  logic [ddap_pkg::DataOutW-1:0] m_axis_tdata_o;
  logic                          m_axis_tuser_o;

  addr_parse_scoreboard tracker = new();

  int unsigned src_idle_pct = 0;
  int unsigned stall_pct    = 0;
  int unsigned items_sent   = 0;
  int unsigned idle_cycles  = 0;
  logic [ddap_pkg::CharW-1:0] text_bytes[$];

  // Sender idle and receiver stall per random phase: none, sender, receiver, both.
  int unsigned src_idle_tab[4] = '{0, 48, 0, 13};
  int unsigned stall_tab[4]    = '{0, 0, 48, 13};

  dotted_decimal_address_parser_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: drop tready at random by the current stall rate.
  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= stall_pct);
  end

  // Monitor both sides. Values read here are the ones sampled at this edge,
  // since every input is driven nonblocking and the block updates in NBA too.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        tracker.note_request(s_axis_tdata_i, s_axis_tlast_i);
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        tracker.check_result(m_axis_tuser_o, m_axis_tdata_o);
      end
    end
  end

  // Watchdog: count cycles in which no request moves on either side.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("dotted_decimal_address_parser_core_tb failed");
      $finish;
    end
  end

  // Offer one request, with random idle cycles ahead of it, and hold it until taken.
  task automatic send_request(logic [ddap_pkg::CharW-1:0] c, logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= c;
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    items_sent++;
  endtask

  // Send the buffered text, then a terminator carrying a junk byte.
  task automatic send_text();
    foreach (text_bytes[i]) send_request(text_bytes[i], 1'b0);
    send_request(ddap_pkg::CharW'($urandom_range(255)), 1'b1);
    text_bytes.delete();
  endtask

  task automatic send_literal(string s);
    text_bytes.delete();
    for (int i = 0; i < s.len(); i++) text_bytes.push_back(s[i]);
    send_text();
  endtask

  // Drop valid, then wait until every owed result is in and the pipeline is drained.
  // The first edge lets the monitor log a terminator taken at this very edge.
  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_mode(logic mode);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mode;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.net_mode = mode;
  endtask

  function automatic void push_blanks(int unsigned n);
    repeat (n) text_bytes.push_back($urandom_range(1) ? ddap_pkg::CharSpace : ddap_pkg::CharTab);
  endfunction

  // Append a part in decimal, now and then with a leading zero.
  function automatic void push_number(int unsigned v);
    if ($urandom_range(7) == 0) text_bytes.push_back(ddap_pkg::CharZero);
    if (v >= 100) text_bytes.push_back(ddap_pkg::CharW'(ddap_pkg::CharZero + v / 100));
    if (v >= 10) text_bytes.push_back(ddap_pkg::CharW'(ddap_pkg::CharZero + (v / 10) % 10));
    text_bytes.push_back(ddap_pkg::CharW'(ddap_pkg::CharZero + v % 10));
  endfunction

  // Build one random text: mostly dotted numbers, some broken, the rest noise.
  function automatic void random_text();
    int unsigned roll;
    int unsigned n_parts;
    int unsigned pick;
    text_bytes.delete();
    roll = $urandom_range(99);
    if (roll < 80) begin
      if ($urandom_range(3) == 0) push_blanks($urandom_range(1, 3));
      pick    = $urandom_range(9);
      n_parts = (pick < 6) ? 4 : (pick == 6) ? 5 : $urandom_range(1, 3);
      for (int i = 0; i < n_parts; i++) begin
        if (i != 0) text_bytes.push_back(ddap_pkg::CharDot);
        pick = $urandom_range(39);
        if (pick == 0) begin
          // leave the part without digits
        end else if (pick == 1) begin
          push_number($urandom_range(256, 999));
        end else if (pick < 4) begin
          push_number(pick == 2 ? 0 : 255);
        end else begin
          push_number($urandom_range(255));
        end
      end
      if ($urandom_range(3) == 0) push_blanks($urandom_range(1, 3));
      pick = $urandom_range(19);
      if (pick == 0) begin
        text_bytes.push_back(ddap_pkg::CharDot);
      end else if (pick == 1) begin
        text_bytes.insert($urandom_range(text_bytes.size()),
                          ddap_pkg::CharW'($urandom_range(255)));
      end else if (pick == 2) begin
        // digit after trailing blank
        push_blanks(1);
        text_bytes.push_back(
          ddap_pkg::CharW'($urandom_range(ddap_pkg::CharZero, ddap_pkg::CharNine)));
      end
    end else begin
      repeat ($urandom_range(6)) begin
        case ($urandom_range(3))
          0: text_bytes.push_back(
               ddap_pkg::CharW'($urandom_range(ddap_pkg::CharZero, ddap_pkg::CharNine)));
          1: text_bytes.push_back(ddap_pkg::CharDot);
          2: push_blanks(1);
          default: text_bytes.push_back(ddap_pkg::CharW'($urandom_range(255)));
        endcase
      end
    end
  endfunction

  initial begin
    int unsigned phase_start;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, address mode: full-range parts with trailing tab, empty and blank text.
    write_mode(1'b0);
    send_literal("255.0.9.1\t");
    send_literal("");
    send_literal("\t");
    settle();

    // Directed, network-number mode: single part, overflow, stray dots,
    // digit after trailing blank, NUL and high bytes.
    write_mode(1'b1);
    send_literal(" 7");
    send_literal("256");
    send_literal("1.");
    send_literal(".1");
    send_literal("1 2");
    text_bytes.push_back(8'hFF);
    send_text();
    text_bytes.push_back(8'h00);
    send_text();
    settle();

    // Random phases: alternate the mode and step through the idle patterns.
    for (int p = 0; p < NumPhases; p++) begin
      write_mode(p[0]);
      src_idle_pct = src_idle_tab[p / 2];
      stall_pct    = stall_tab[p / 2];
      phase_start  = items_sent;
      while (items_sent < phase_start + ItemsPerPhase) begin
        random_text();
        send_text();
      end
      settle();
    end

    if (tracker.error_count == 0 && tracker.pending() == 0) begin
      $display("dotted_decimal_address_parser_core_tb passed");
    end else begin
      $display("dotted_decimal_address_parser_core_tb failed");
    end
    $finish;
  end

endmodule
